### rtl/epsd_pkg.sv
// Shared types and constants for the pulse-width serial deframer.
package epsd_pkg;

    localparam int MAX_BYTES_DEF   = 24;
    localparam int BIT_TIME_MS_DEF = 8;

    // packet framing
    localparam int PREAMBLE_BITS    = 15;
    localparam int ID_BITS          = 4;
    localparam int FRAME_BITS       = 11;
    localparam int LAST_DATA_POS    = 8;
    localparam int FIRST_STOP_POS   = 9;
    localparam int LAST_STOP_POS    = 10;
    localparam int NEXT_FOLLOW_BITS = 16;

    localparam int TS_W   = 32;
    localparam int BITS_W = 16;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // result kinds
    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_START_ER = 2'd1;
    localparam logic [1:0] KIND_STOP_ER  = 2'd2;

    // register indexes
    localparam logic [0:0] REG_HIGH_LEVEL = 1'b0;
    localparam logic [0:0] REG_LOW_LEVEL  = 1'b1;

    typedef struct packed {
        logic capture;
        logic hunt;
        logic div_start;
        logic div_step;
        logic bit_step;
        logic rd;
        logic load_byte;
        logic load_err;
    } t_cmd;

    typedef struct packed {
        logic in_packet;
        logic div_done;
        logic bits_zero;
        logic step_err;
        logic step_end;
        logic out_free;
        logic last_byte;
    } t_sts;

endpackage

### rtl/epsd_ctrl.sv
// Sequencer for the deframer: edge intake, division, bit walk and result run.
module epsd_ctrl
    import epsd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_BITS = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_LD   = 3'd5;
    localparam logic [2:0] S_ERR  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.in_packet) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.hunt = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_BITS;
                end
            end
            S_BITS: begin
                if (i_sts.bits_zero) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.bit_step = 1'b1;
                    if (i_sts.step_err) begin
                        n_state = S_ERR;
                    end else if (i_sts.step_end) begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_LD;
            end
            S_LD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_byte = 1'b1;
                    n_state         = i_sts.last_byte ? S_IDLE : S_RD;
                end
            end
            S_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.load_err = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/epsd_dp.sv
// Datapath: timing, reciprocal divide, bit framing, byte memory and output register.
module epsd_dp
    import epsd_pkg::*;
#(
    parameter int MAX_BYTES   = MAX_BYTES_DEF,
    parameter int BIT_TIME_MS = BIT_TIME_MS_DEF,
    parameter int IDX_W       = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1,
    parameter int CNT_W       = $clog2(ID_BITS + FRAME_BITS * MAX_BYTES + 1)
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_high_level,
    input  logic             i_low_level,
    input  logic             i_line_level,
    input  logic [TS_W-1:0]  i_now_ms,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_kind,
    output logic [3:0]       o_car_id,
    output logic [IDX_W-1:0] o_byte_index,
    output logic [7:0]       o_byte_value,
    output logic [CNT_W-1:0] o_bit_position,
    output logic             o_next_follows,
    output logic             o_last
);

    localparam int HALF   = TS_W / 2;
    localparam int RCP_SH = TS_W + $clog2(BIT_TIME_MS);
    localparam int RCP_W  = TS_W + 2;
    localparam int PROD_W = HALF + RCP_W;
    localparam int ACC_W  = TS_W + RCP_W;
    // reciprocal rounded up: exact floor division for every 32-bit dividend
    localparam logic [RCP_W-1:0]  RCP       =
        RCP_W'(((64'd1 << RCP_SH) + 64'(BIT_TIME_MS - 1)) / 64'(BIT_TIME_MS));
    localparam logic [TS_W-1:0]   PRE_LIMIT = TS_W'(PREAMBLE_BITS * BIT_TIME_MS);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(MAX_BYTES - 1);

    // edge and packet state
    logic             r_level;
    logic [TS_W-1:0]  r_now;
    logic [TS_W-1:0]  r_mark;
    logic             r_in_packet;
    logic [CNT_W-1:0] r_cnt;
    logic [3:0]       r_fpos;
    logic [IDX_W-1:0] r_byte;
    logic [3:0]       r_id;
    logic [7:0]       r_cur;

    // divider: low half product first, high half added on the second step
    logic [TS_W-1:0]   r_dvd;
    logic [PROD_W-1:0] r_acc;
    logic [BITS_W-1:0] r_bits;
    logic              r_dcnt;

    // result run
    logic             r_nf;
    logic [IDX_W-1:0] r_rd_idx;
    logic [IDX_W-1:0] r_last_idx;
    logic [7:0]       r_rd_data;
    logic [1:0]       r_err_kind;
    logic [CNT_W-1:0] r_err_pos;

    logic [7:0] mem [MAX_BYTES];

    logic [TS_W-1:0]   elapsed;
    logic [HALF-1:0]   mul_in;
    logic [PROD_W-1:0] prod;
    logic [ACC_W-1:0]  acc_sum;
    logic              is_id;
    logic              is_start;
    logic              is_data;
    logic              is_stop;
    logic              start_bad;
    logic              stop_bad;
    logic              pkt_end;
    logic              one_bit;
    logic [3:0]        id_base;
    logic [7:0]        cur_next;
    logic              out_free;

    assign elapsed = r_now - r_mark;
    assign mul_in  = r_dcnt ? r_dvd[TS_W-1:HALF] : r_dvd[HALF-1:0];
    assign prod    = PROD_W'(mul_in) * PROD_W'(RCP);
    assign acc_sum = ACC_W'(r_acc) + {prod, {HALF{1'b0}}};

    assign is_id     = (r_cnt < CNT_W'(ID_BITS));
    assign is_start  = !is_id && (r_fpos == 4'd0);
    assign is_data   = !is_id && (r_fpos != 4'd0) && (r_fpos <= 4'(LAST_DATA_POS));
    assign is_stop   = !is_id && (r_fpos >= 4'(FIRST_STOP_POS));
    assign start_bad = is_start && (r_level != i_high_level);
    assign stop_bad  = is_stop && (r_level != i_low_level);
    assign pkt_end   = is_stop && !stop_bad && (r_fpos == 4'(LAST_STOP_POS))
                       && ((r_bits > BITS_W'(1)) || (r_byte == LAST_IDX));
    assign one_bit   = (r_level == i_low_level);
    assign id_base   = (r_cnt == '0) ? 4'd0 : r_id;
    assign cur_next  = {one_bit, r_cur[7:1]};
    assign out_free  = !o_out_valid || i_out_ready;

    assign o_sts.in_packet = r_in_packet;
    assign o_sts.div_done  = r_dcnt;
    assign o_sts.bits_zero = (r_bits == '0);
    assign o_sts.step_err  = start_bad || stop_bad;
    assign o_sts.step_end  = pkt_end;
    assign o_sts.out_free  = out_free;
    assign o_sts.last_byte = (r_rd_idx == r_last_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_level <= i_line_level;
            r_now   <= i_now_ms;
        end
        if (i_cmd.div_start) begin
            r_dvd  <= elapsed + TS_W'(1);
            r_dcnt <= 1'b0;
        end else if (i_cmd.div_step) begin
            if (!r_dcnt) begin
                r_acc  <= prod;
                r_dcnt <= 1'b1;
            end else begin
                r_bits <= acc_sum[RCP_SH +: BITS_W];
            end
        end else if (i_cmd.bit_step) begin
            r_bits <= r_bits - BITS_W'(1);
        end
        if (i_cmd.bit_step && is_data) begin
            r_cur <= cur_next;
        end
        if (i_cmd.bit_step && start_bad) begin
            r_err_kind <= KIND_START_ER;
            r_err_pos  <= r_cnt;
        end else if (i_cmd.bit_step && stop_bad) begin
            r_err_kind <= KIND_STOP_ER;
            r_err_pos  <= r_cnt;
        end
        if (i_cmd.bit_step && pkt_end) begin
            r_nf       <= (r_bits >= BITS_W'(NEXT_FOLLOW_BITS));
            r_last_idx <= r_byte;
            r_rd_idx   <= '0;
        end else if (i_cmd.load_byte) begin
            r_rd_idx <= r_rd_idx + IDX_W'(1);
        end
    end

    // packet state, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
            r_mark      <= '0;
            r_cnt       <= '0;
            r_fpos      <= '0;
            r_byte      <= '0;
            r_id        <= '0;
        end else begin
            if (i_cmd.hunt) begin
                if (r_level == i_high_level) begin
                    r_mark <= r_now;
                end else if (elapsed > PRE_LIMIT) begin
                    r_mark      <= r_now;
                    r_in_packet <= 1'b1;
                    r_cnt       <= '0;
                    r_fpos      <= '0;
                    r_byte      <= '0;
                end
            end
            if (i_cmd.div_start) begin
                r_mark <= r_now;
            end
            if (i_cmd.bit_step) begin
                if (start_bad || stop_bad) begin
                    r_in_packet <= 1'b0;
                end else if (pkt_end) begin
                    if (r_bits >= BITS_W'(NEXT_FOLLOW_BITS)) begin
                        r_cnt  <= '0;
                        r_fpos <= '0;
                        r_byte <= '0;
                    end else begin
                        r_in_packet <= 1'b0;
                    end
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (is_id) begin
                        r_id <= {one_bit, id_base[3:1]};
                    end else if (r_fpos == 4'(LAST_STOP_POS)) begin
                        r_fpos <= '0;
                        r_byte <= r_byte + IDX_W'(1);
                    end else begin
                        r_fpos <= r_fpos + 4'd1;
                    end
                end
            end
        end
    end

    // byte memory: written on the last data bit of a frame
    always_ff @(posedge i_clk) begin
        if (i_cmd.bit_step && is_data && (r_fpos == 4'(LAST_DATA_POS))) begin
            mem[r_byte] <= cur_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= mem[r_rd_idx];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_byte || i_cmd.load_err) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            o_kind         <= KIND_BYTE;
            o_car_id       <= r_id;
            o_byte_index   <= r_rd_idx;
            o_byte_value   <= r_rd_data;
            o_bit_position <= '0;
            o_next_follows <= r_nf;
            o_last         <= (r_rd_idx == r_last_idx);
        end else if (i_cmd.load_err) begin
            o_kind         <= r_err_kind;
            o_car_id       <= '0;
            o_byte_index   <= '0;
            o_byte_value   <= '0;
            o_bit_position <= r_err_pos;
            o_next_follows <= 1'b0;
            o_last         <= 1'b1;
        end
    end

endmodule

### rtl/ecu_pulse_serial_deframer_top.sv
// Top level of the pulse-width serial deframer: register port and wiring.
//
// Input channel (i_in_valid / o_in_ready): one beat per line edge, carrying
// the line level after the edge and a 32-bit millisecond timestamp.
// Output channel (o_out_valid / i_out_ready): one beat per result, either a
// packet byte (runs of up to MAX_BYTES beats, o_last on the final one) or a
// single start/stop framing error beat.
// Edges are taken one at a time. An edge while hunting for the preamble is
// captured, then evaluated. An edge inside a packet is captured, evaluated,
// and turned from elapsed time into bit times by a low-half then high-half
// reciprocal multiply; the bit times are then walked one at a time (a packet
// always ends within its ID and frame bits) until the count runs out, an error
// beat is loaded, or each result byte is read from memory and then loaded.
// When the receiver stalls, the result waits in the output register; the
// next edge is still accepted once the run is handed over, but the next
// result beat waits until the register is free.
// Reset returns to hunting with the high level register at 1 and the low
// level register at 0; the byte memory is not cleared.
module ecu_pulse_serial_deframer_top
    import epsd_pkg::*;
#(
    parameter int MAX_BYTES   = MAX_BYTES_DEF,
    parameter int BIT_TIME_MS = BIT_TIME_MS_DEF,
    parameter int IDX_W       = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1,
    parameter int CNT_W       = $clog2(ID_BITS + FRAME_BITS * MAX_BYTES + 1)
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_line_level,
    input  logic [TS_W-1:0]   i_now_ms,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_kind,
    output logic [3:0]        o_car_id,
    output logic [IDX_W-1:0]  o_byte_index,
    output logic [7:0]        o_byte_value,
    output logic [CNT_W-1:0]  o_bit_position,
    output logic              o_next_follows,
    output logic              o_last
);

    logic       r_high_level;
    logic       r_low_level;
    logic [0:0] reg_idx;
    logic       wr_en;
    t_cmd       cmd;
    t_sts       sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        case (reg_idx)
            REG_HIGH_LEVEL: prdata = {{(APB_DW-1){1'b0}}, r_high_level};
            REG_LOW_LEVEL:  prdata = {{(APB_DW-1){1'b0}}, r_low_level};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_level <= 1'b1;
            r_low_level  <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_HIGH_LEVEL: r_high_level <= pwdata[0];
                REG_LOW_LEVEL:  r_low_level  <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    epsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    epsd_dp #(
        .MAX_BYTES   (MAX_BYTES),
        .BIT_TIME_MS (BIT_TIME_MS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_high_level   (r_high_level),
        .i_low_level    (r_low_level),
        .i_line_level   (i_line_level),
        .i_now_ms       (i_now_ms),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_car_id       (o_car_id),
        .o_byte_index   (o_byte_index),
        .o_byte_value   (o_byte_value),
        .o_bit_position (o_bit_position),
        .o_next_follows (o_next_follows),
        .o_last         (o_last)
    );

endmodule

### sim/tb.sv
// Testbench for ecu_pulse_serial_deframer_top: edge stimulus, line-level predictor, beat checks.
module tb
    import epsd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SETTLE_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned LONG_HOLD     = 2500;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] car_id;
        logic [4:0] byte_index;
        logic [7:0] byte_value;
        logic [8:0] bit_position;
        logic       next_follows;
        logic       last;
    } t_deframe_beat;

    typedef bit [7:0] t_byte_q[$];

    typedef enum int {
        FLAW_NONE,
        FLAW_START,
        FLAW_STOP
    } t_flaw;

    // Tracks the deframer state edge by edge and holds the beats still owed.
    class t_deframe_board;
        bit            hi_lvl;
        bit            lo_lvl;
        bit            in_pkt;
        bit [TS_W-1:0] mark_ms;
        int unsigned   bit_cnt;
        bit [3:0]      id_bits;
        bit [7:0]      byte_mem [MAX_BYTES_DEF];
        t_deframe_beat beats_due [$];
        int unsigned   errors;

        function new();
            hi_lvl     = 1'b1;
            lo_lvl     = 1'b0;
            in_pkt     = 1'b0;
            mark_ms    = '0;
            bit_cnt    = 0;
            id_bits    = '0;
            errors     = 0;
            foreach (byte_mem[i]) byte_mem[i] = '0;
        endfunction

        function void set_reg(logic [0:0] idx, bit val);
            case (idx)
                REG_HIGH_LEVEL: hi_lvl = val;
                REG_LOW_LEVEL:  lo_lvl = val;
                default: ;
            endcase
        endfunction

        function void add_beat(logic [1:0] kind, bit [3:0] id, int unsigned idx,
                               bit [7:0] val, int unsigned pos, bit nf, bit last);
            t_deframe_beat b;
            b.kind         = kind;
            b.car_id       = id;
            b.byte_index   = 5'(idx);
            b.byte_value   = val;
            b.bit_position = 9'(pos);
            b.next_follows = nf;
            b.last         = last;
            beats_due.push_back(b);
        endfunction

        function void take_edge(bit lvl, bit [TS_W-1:0] stamp);
            bit [TS_W-1:0] elapsed;
            bit [TS_W-1:0] plus_one;
            int unsigned   bits_left;
            int unsigned   bitpos;
            int unsigned   bytepos;
            bit            nf;
            elapsed = stamp - mark_ms;
            if (!in_pkt) begin
                if (lvl == hi_lvl) begin
                    mark_ms = stamp;
                end else if (elapsed > 32'(PREAMBLE_BITS * BIT_TIME_MS_DEF)) begin
                    mark_ms = stamp;
                    in_pkt  = 1'b1;
                    bit_cnt = 0;
                end
                return;
            end
            // elapsed+1 wraps to zero when elapsed is all ones
            plus_one  = elapsed + 32'd1;
            bits_left = (plus_one / 32'(BIT_TIME_MS_DEF)) & 32'h0000_FFFF;
            mark_ms   = stamp;
            while (bits_left > 0) begin
                if (bit_cnt < ID_BITS) begin
                    if (bit_cnt == 0) id_bits = '0;
                    id_bits = {lvl == lo_lvl, id_bits[3:1]};
                end else begin
                    bitpos  = (bit_cnt - ID_BITS) % FRAME_BITS;
                    bytepos = (bit_cnt - ID_BITS) / FRAME_BITS;
                    if (bytepos >= MAX_BYTES_DEF) bytepos = MAX_BYTES_DEF - 1;
                    if (bitpos == 0) begin
                        if (lvl != hi_lvl) begin
                            add_beat(KIND_START_ER, 0, 0, 0, bit_cnt, 0, 1);
                            in_pkt = 1'b0;
                            return;
                        end
                    end else if (bitpos <= LAST_DATA_POS) begin
                        byte_mem[bytepos] = {lvl == lo_lvl, byte_mem[bytepos][7:1]};
                    end else begin
                        if (lvl != lo_lvl) begin
                            add_beat(KIND_STOP_ER, 0, 0, 0, bit_cnt, 0, 1);
                            in_pkt = 1'b0;
                            return;
                        end
                        if (bitpos == LAST_STOP_POS &&
                            (bits_left > 1 || bytepos == MAX_BYTES_DEF - 1)) begin
                            nf = (bits_left >= NEXT_FOLLOW_BITS);
                            for (int i = 0; i <= bytepos; i++)
                                add_beat(KIND_BYTE, id_bits, i, byte_mem[i], 0, nf,
                                         i == bytepos);
                            if (nf) bit_cnt = 0;
                            else in_pkt = 1'b0;
                            return;
                        end
                    end
                end
                bit_cnt++;
                bits_left--;
            end
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_beat(t_deframe_beat got);
            t_deframe_beat want;
            string         bad;
            if (beats_due.size() == 0) begin
                report($sformatf("beat with nothing due: %p", got));
                return;
            end
            want = beats_due.pop_front();
            bad  = "";
            if (got.kind !== want.kind) bad = {bad, " kind"};
            if (got.car_id !== want.car_id) bad = {bad, " car_id"};
            if (got.byte_index !== want.byte_index) bad = {bad, " byte_index"};
            if (got.byte_value !== want.byte_value) bad = {bad, " byte_value"};
            if (got.bit_position !== want.bit_position) bad = {bad, " bit_position"};
            if (got.next_follows !== want.next_follows) bad = {bad, " next_follows"};
            if (got.last !== want.last) bad = {bad, " last"};
            if (bad != "") report($sformatf("bad%s: got %p want %p", bad, got, want));
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_line_level;
    logic [TS_W-1:0]   i_now_ms;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [1:0]        o_kind;
    logic [3:0]        o_car_id;
    logic [4:0]        o_byte_index;
    logic [7:0]        o_byte_value;
    logic [8:0]        o_bit_position;
    logic              o_next_follows;
    logic              o_last;

    t_deframe_board board;
    bit [TS_W-1:0]  line_ms;
    bit             calm = 1'b0;
    int unsigned    edges_taken = 0;
    int unsigned    sink_hold = 0;
    int unsigned    sink_gap = 0;
    bit             long_hold_done = 1'b0;
    int unsigned    cycle_count = 0;

    ecu_pulse_serial_deframer_top i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ecu_pulse_serial_deframer_top regression: fail");
            $finish;
        end
    end

    // Result side: random stall bursts, plus one long hold once a beat is waiting
    // so the block backs up into its input.
    always @(negedge i_clk) begin
        if (!long_hold_done && edges_taken >= 120 && o_out_valid === 1'b1) begin
            sink_hold      = LONG_HOLD;
            long_hold_done = 1'b1;
        end
        if (sink_hold > 0) sink_hold--;
        else if (sink_gap > 0) sink_gap--;
        else if (!calm && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 18);
        i_out_ready <= (sink_hold == 0 && sink_gap == 0);
    end

    always @(posedge i_clk) begin
        t_deframe_beat got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.kind         = o_kind;
            got.car_id       = o_car_id;
            got.byte_index   = o_byte_index;
            got.byte_value   = o_byte_value;
            got.bit_position = o_bit_position;
            got.next_follows = o_next_follows;
            got.last         = o_last;
            board.check_beat(got);
        end
    end

    task automatic idle(input int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    task automatic send_edge(input bit lvl, input bit [TS_W-1:0] stamp);
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_line_level <= lvl;
        i_now_ms     <= stamp;
        do @(posedge i_clk); while (!o_in_ready);
        board.take_edge(lvl, stamp);
        edges_taken++;
        if (!calm && $urandom_range(0, 4) == 0) idle($urandom_range(1, 18));
    endtask

    task automatic send_after(input bit lvl, input bit [TS_W-1:0] gap);
        line_ms += gap;
        send_edge(lvl, line_ms);
    endtask

    // gap lands anywhere inside the window that still rounds to nbits
    task automatic send_run(input bit lvl, input int unsigned nbits);
        send_after(lvl, BIT_TIME_MS_DEF * nbits - 1 + $urandom_range(0, BIT_TIME_MS_DEF - 1));
    endtask

    task automatic write_reg(input logic [0:0] idx, input bit val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DW'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_reg(idx, val);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_preamble();
        if ($urandom_range(0, 1)) begin
            send_after(board.hi_lvl, $urandom_range(1, 300));
            // too soon after the high edge: ignored
            if ($urandom_range(0, 2) == 0) send_after(!board.hi_lvl, $urandom_range(1, 120));
        end
        send_after(!board.hi_lvl, $urandom_range(121, 400));
    endtask

    task automatic send_packet(input bit [3:0] car, input t_byte_q data, input t_flaw flaw,
                               input int unsigned extras);
        bit          line [$];
        bit          hi;
        bit          lo;
        int unsigned k;
        int unsigned n;
        int unsigned part;
        int unsigned frame;
        hi = board.hi_lvl;
        lo = board.lo_lvl;
        for (k = 0; k < ID_BITS; k++) line.push_back(car[k] ? lo : !lo);
        foreach (data[i]) begin
            line.push_back(hi);
            for (k = 0; k < 8; k++) line.push_back(data[i][k] ? lo : !lo);
            line.push_back(lo);
            line.push_back(lo);
        end
        frame = $urandom_range(0, data.size() - 1);
        if (flaw == FLAW_START)
            line[ID_BITS + frame * FRAME_BITS] = !hi;
        else if (flaw == FLAW_STOP)
            line[ID_BITS + frame * FRAME_BITS + $urandom_range(FIRST_STOP_POS, LAST_STOP_POS)] = !lo;
        repeat (extras) line.push_back(lo);
        k = 0;
        while (k < line.size()) begin
            n = 1;
            while (k + n < line.size() && line[k + n] == line[k]) n++;
            // closing run stays one edge so the spare bit times land on the last stop bit
            while (n > 0) begin
                part = (k + n == line.size() || $urandom_range(0, 3) != 0) ?
                       n : $urandom_range(1, n);
                send_run(line[k], part);
                k += part;
                n -= part;
            end
        end
    endtask

    task automatic random_sequence();
        int unsigned pick;
        int unsigned nbytes;
        int unsigned extras;
        t_flaw       flaw;
        t_byte_q     data;
        pick = $urandom_range(0, 19);
        if (pick < 3) begin
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 3) == 0) line_ms = $urandom;
                else line_ms += $urandom_range(0, 300);
                send_edge(1'($urandom_range(0, 1)), line_ms);
            end
            return;
        end
        // a long run always ends a packet left half done by noise
        repeat (4) if (board.in_pkt && board.bit_cnt != 0) send_run(!board.hi_lvl, 40);
        if (!board.in_pkt) send_preamble();
        nbytes = ($urandom_range(0, 14) == 0) ? MAX_BYTES_DEF : $urandom_range(1, 6);
        repeat (nbytes) data.push_back(8'($urandom_range(0, 255)));
        if (pick < 6) flaw = $urandom_range(0, 1) ? FLAW_START : FLAW_STOP;
        else flaw = FLAW_NONE;
        if (nbytes == MAX_BYTES_DEF && $urandom_range(0, 1))
            extras = 0;
        else if ($urandom_range(0, 2) == 0)
            extras = $urandom_range(NEXT_FOLLOW_BITS - 1, NEXT_FOLLOW_BITS + 4);
        else
            extras = $urandom_range(1, NEXT_FOLLOW_BITS - 2);
        send_packet(4'($urandom_range(0, 15)), data, flaw, extras);
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned goal;
        goal = edges_taken + count;
        while (edges_taken < goal) random_sequence();
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.beats_due.size() != 0) @(posedge i_clk);
        // hunting edges make no beats but may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic directed_part();
        // preamble threshold straddling the timestamp wrap: 120 ms is not enough, 121 is
        line_ms = 32'hFFFF_FFA0;
        send_edge(board.hi_lvl, line_ms);
        send_after(!board.hi_lvl, PREAMBLE_BITS * BIT_TIME_MS_DEF);
        send_after(!board.hi_lvl, 1);
        // all-ones byte with exactly 16 bit times left: next packet follows at once
        send_packet(4'hF, {8'hFF}, FLAW_NONE, NEXT_FOLLOW_BITS - 1);
        send_packet(4'h0, {8'h00}, FLAW_NONE, 1);
        send_after(!board.hi_lvl, 200);
        // elapsed of all ones gives zero bit times, then a backward jump runs long
        send_after(board.lo_lvl, 32'hFFFF_FFFF);
        send_after(!board.hi_lvl, 32'hFFFF_FC18);
        send_preamble();
        send_packet(4'h5, {8'h5A, 8'hA5}, FLAW_STOP, 3);
        send_preamble();
        send_packet(4'hA, {8'h3C}, FLAW_START, 2);
    endtask

    initial begin
        board        = new();
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_in_valid   = 1'b0;
        i_line_level = 1'b0;
        i_now_ms     = '0;
        i_out_ready  = 1'b0;
        line_ms      = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_part();
        run_random(130);

        drain();
        write_reg(REG_HIGH_LEVEL, 1'b0);
        write_reg(REG_LOW_LEVEL, 1'b1);
        run_random(90);

        // both levels equal: every test is plain equality
        drain();
        write_reg(REG_HIGH_LEVEL, 1'b1);
        run_random(45);

        drain();
        write_reg(REG_HIGH_LEVEL, 1'b0);
        write_reg(REG_LOW_LEVEL, 1'b0);
        run_random(35);

        drain();
        write_reg(REG_HIGH_LEVEL, 1'b1);
        calm = 1'b1;
        run_random(55);

        drain();
        if (board.errors == 0)
            $display("ecu_pulse_serial_deframer_top regression: pass");
        else
            $display("ecu_pulse_serial_deframer_top regression: fail");
        $finish;
    end
endmodule

### sim.f
rtl/epsd_pkg.sv
rtl/epsd_ctrl.sv
rtl/epsd_dp.sv
rtl/ecu_pulse_serial_deframer_top.sv
sim/tb.sv
